// ===== sv/feathered_tile_blend_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the feathered tile blender
// Shared property wrappers: clock, reset qualifier and error report in one place.
// ----------------------------------------------------------------------------
`ifndef FEATHERED_TILE_BLEND_TOP_MACROS_SVH
`define FEATHERED_TILE_BLEND_TOP_MACROS_SVH

// Generic form with explicit clock and active-low reset.
`define FTB_ASSERT_CLK(clk_sig, rst_sig, label, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Short form on the block clock and reset.
`define FTB_ASSERT(label, prop, msg) `FTB_ASSERT_CLK(clk, rst_n, label, prop, msg)

`endif

// ===== sv/ftb_pkg.sv =====
// ----------------------------------------------------------------------------
// ftb_pkg
// Types and constants shared by the feathered tile blender modules.
// ----------------------------------------------------------------------------
package ftb_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 16;
    localparam int GUARD_W = 12;
    localparam int CNT_W   = 17;
    localparam int POS_W   = 19;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Image positions carry one extra bit so the sign survives the guard offset.
    localparam int SPOS_W = POS_W + 1;

    // Divisor is twice the guard; remainder needs one bit more for the shift.
    localparam int DEN_W = GUARD_W + 1;
    localparam int REM_W = DEN_W + 1;

    // Weights are unsigned Q1.16.
    localparam int Q_W  = 16;
    localparam int WT_W = Q_W + 1;
    localparam logic [WT_W-1:0] WT_ONE = WT_W'(1) << Q_W;

    localparam int DIV_STEPS = Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_TILE_WIDTH   = 3'd2,
        REG_TILE_HEIGHT  = 3'd3,
        REG_GUARD_W      = 3'd4,
        REG_GUARD_H      = 3'd5,
        REG_IMAGE_WIDTH  = 3'd6,
        REG_IMAGE_HEIGHT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]   origin_x;
        logic [CFG_W-1:0]   origin_y;
        logic [CFG_W-1:0]   tile_width;
        logic [CFG_W-1:0]   tile_height;
        logic [GUARD_W-1:0] guard_w;
        logic [GUARD_W-1:0] guard_h;
        logic [CFG_W-1:0]   image_width;
        logic [CFG_W-1:0]   image_height;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic load;
        logic check;
        logic div_step;
        logic mul_weight;
        logic mul_chan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage

// ===== sv/ftb_regs.sv =====
// ----------------------------------------------------------------------------
// ftb_regs
// APB-style configuration register file for the tile blender.
// ----------------------------------------------------------------------------
module ftb_regs
    import ftb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.tile_width   <= CFG_W'(1);
            cfg_reg.tile_height  <= CFG_W'(1);
            cfg_reg.guard_w      <= '0;
            cfg_reg.guard_h      <= '0;
            cfg_reg.image_width  <= CFG_W'(1);
            cfg_reg.image_height <= CFG_W'(1);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_ORIGIN_X:     cfg_reg.origin_x     <= pwdata[CFG_W-1:0];
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= pwdata[CFG_W-1:0];
                REG_TILE_WIDTH:   cfg_reg.tile_width   <= pwdata[CFG_W-1:0];
                REG_TILE_HEIGHT:  cfg_reg.tile_height  <= pwdata[CFG_W-1:0];
                REG_GUARD_W:      cfg_reg.guard_w      <= pwdata[GUARD_W-1:0];
                REG_GUARD_H:      cfg_reg.guard_h      <= pwdata[GUARD_W-1:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[CFG_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ORIGIN_X:     prdata = DATA_W'(cfg_reg.origin_x);
            REG_ORIGIN_Y:     prdata = DATA_W'(cfg_reg.origin_y);
            REG_TILE_WIDTH:   prdata = DATA_W'(cfg_reg.tile_width);
            REG_TILE_HEIGHT:  prdata = DATA_W'(cfg_reg.tile_height);
            REG_GUARD_W:      prdata = DATA_W'(cfg_reg.guard_w);
            REG_GUARD_H:      prdata = DATA_W'(cfg_reg.guard_h);
            REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_reg.image_height);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== sv/ftb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftb_ctrl
// Sequencer for one pixel: load, check, serial divide, two multiplies, finish.
// ----------------------------------------------------------------------------
module ftb_ctrl
    import ftb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOAD   = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_MULW   = 7'b0010000,
        S_MULC   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check    = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_MULW;
                end
            end
            S_MULW:
            begin
                cmd.mul_weight = 1'b1;
                state_next     = S_MULC;
            end
            S_MULC:
            begin
                cmd.mul_chan = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                // Wait here while the previous result still sits unclaimed.
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// ===== sv/ftb_dpath.sv =====
// ----------------------------------------------------------------------------
// ftb_dpath
// Scan counters, feather weight ramps, restoring divider and channel blend.
// ----------------------------------------------------------------------------
module ftb_dpath
    import ftb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [PIX_W-1:0]  src_b,
    input  logic [PIX_W-1:0]  src_g,
    input  logic [PIX_W-1:0]  src_r,
    input  logic [PIX_W-1:0]  dst_b,
    input  logic [PIX_W-1:0]  dst_g,
    input  logic [PIX_W-1:0]  dst_r,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  out_b,
    output logic [PIX_W-1:0]  out_g,
    output logic [PIX_W-1:0]  out_r,
    output logic              in_image,
    output logic [POS_W-1:0]  image_x,
    output logic [POS_W-1:0]  image_y,
    output logic              last
);

    typedef struct packed {
        logic             ramp;
        logic [DEN_W-1:0] num;
    } ramp_t;

    // Ramp numerator for one axis; num is always below the divisor when ramp is set.
    function automatic ramp_t axis_ramp(input logic [CNT_W-1:0] cnt,
                                        input logic [CFG_W-1:0] size,
                                        input logic [GUARD_W-1:0] guard);
        logic [DEN_W-1:0] den;
        logic             lead;
        logic             trail;
        logic [CNT_W-1:0] over;
        ramp_t            r;
        den    = {guard, 1'b0};
        lead   = cnt < CNT_W'(den);
        trail  = cnt > CNT_W'(size);
        over   = cnt - CNT_W'(size);
        r.ramp = lead || (trail && (den != '0));
        if (lead)
        begin
            r.num = cnt[DEN_W-1:0];
        end
        else if (over >= CNT_W'(den))
        begin
            r.num = '0;
        end
        else
        begin
            r.num = den - over[DEN_W-1:0];
        end
        return r;
    endfunction

    // Image-border pixels keep full weight.
    function automatic logic at_border(input logic [POS_W-1:0] pos,
                                       input logic [GUARD_W-1:0] guard,
                                       input logic [CFG_W-1:0] extent);
        logic [POS_W:0] reach;
        reach = {1'b0, pos} + (POS_W+1)'(guard);
        return (pos < POS_W'(guard)) || (reach > (POS_W+1)'(extent));
    endfunction

    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W] ? {PIX_W{1'b1}} : s[PIX_W-1:0];
    endfunction

    // Scan position
    logic [CNT_W-1:0] col_reg, row_reg;
    logic [CNT_W:0]   col_inc, row_inc, scan_w, scan_h;
    logic             row_end, scan_end;

    // Captured item
    logic [PIX_W-1:0] sb_reg, sg_reg, sr_reg, db_reg, dg_reg, dr_reg;
    logic [CNT_W-1:0] col_i_reg, row_i_reg;
    logic             last_i_reg;

    // Position and ramp setup
    logic signed [SPOS_W-1:0] fx_c, fy_c;
    logic signed [SPOS_W-1:0] fx_reg, fy_reg;
    ramp_t                    rx_c, ry_c, rx_reg, ry_reg;
    logic                     inside_reg, use_x_reg, use_y_reg;
    logic                     inside_c;

    // Divider lanes
    logic [DEN_W-1:0] den_x, den_y;
    logic [REM_W-1:0] remx_reg, remy_reg, remx_sh, remy_sh;
    logic             gex, gey;
    logic [Q_W-1:0]   qx_reg, qy_reg;

    // Multiplies
    logic [WT_W-1:0]   wx, wy, w_reg;
    logic [2*WT_W-1:0] wprod;
    logic [WT_W+PIX_W-1:0] pb, pg, pr;
    logic [PIX_W-1:0]  pb_reg, pg_reg, pr_reg;

    // Output register
    logic              out_valid_reg;
    logic [PIX_W-1:0]  ob_reg, og_reg, or_reg;
    logic              in_image_reg, last_reg;
    logic [POS_W-1:0]  ix_reg, iy_reg;

    assign col_inc  = {1'b0, col_reg} + (CNT_W+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (CNT_W+1)'(1);
    assign scan_w   = (CNT_W+1)'(cfg.tile_width) + (CNT_W+1)'({cfg.guard_w, 1'b0});
    assign scan_h   = (CNT_W+1)'(cfg.tile_height) + (CNT_W+1)'({cfg.guard_h, 1'b0});
    assign row_end  = col_inc >= scan_w;
    assign scan_end = row_end && (row_inc >= scan_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.take)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= scan_end ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sb_reg     <= src_b;
            sg_reg     <= src_g;
            sr_reg     <= src_r;
            db_reg     <= dst_b;
            dg_reg     <= dst_g;
            dr_reg     <= dst_r;
            col_i_reg  <= col_reg;
            row_i_reg  <= row_reg;
            last_i_reg <= scan_end;
        end
    end

    assign fx_c = $signed(SPOS_W'(cfg.origin_x)) - $signed(SPOS_W'(cfg.guard_w))
                + $signed(SPOS_W'(col_i_reg));
    assign fy_c = $signed(SPOS_W'(cfg.origin_y)) - $signed(SPOS_W'(cfg.guard_h))
                + $signed(SPOS_W'(row_i_reg));
    assign rx_c = axis_ramp(col_i_reg, cfg.tile_width, cfg.guard_w);
    assign ry_c = axis_ramp(row_i_reg, cfg.tile_height, cfg.guard_h);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fx_reg <= fx_c;
            fy_reg <= fy_c;
            rx_reg <= rx_c;
            ry_reg <= ry_c;
        end
    end

    assign inside_c = !fx_reg[SPOS_W-1] && !fy_reg[SPOS_W-1]
                   && (fx_reg[POS_W-1:0] < POS_W'(cfg.image_width))
                   && (fy_reg[POS_W-1:0] < POS_W'(cfg.image_height));

    assign den_x   = {cfg.guard_w, 1'b0};
    assign den_y   = {cfg.guard_h, 1'b0};
    assign remx_sh = {remx_reg[REM_W-2:0], 1'b0};
    assign remy_sh = {remy_reg[REM_W-2:0], 1'b0};
    assign gex     = remx_sh >= REM_W'(den_x);
    assign gey     = remy_sh >= REM_W'(den_y);

    // One quotient bit per step for both axes: floor(num * 2^16 / den).
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            inside_reg <= inside_c;
            use_x_reg  <= rx_reg.ramp
                       && !at_border(fx_reg[POS_W-1:0], cfg.guard_w, cfg.image_width);
            use_y_reg  <= ry_reg.ramp
                       && !at_border(fy_reg[POS_W-1:0], cfg.guard_h, cfg.image_height);
            remx_reg   <= REM_W'(rx_reg.num);
            remy_reg   <= REM_W'(ry_reg.num);
            qx_reg     <= '0;
            qy_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            remx_reg <= gex ? (remx_sh - REM_W'(den_x)) : remx_sh;
            remy_reg <= gey ? (remy_sh - REM_W'(den_y)) : remy_sh;
            qx_reg   <= {qx_reg[Q_W-2:0], gex};
            qy_reg   <= {qy_reg[Q_W-2:0], gey};
        end
    end

    assign wx    = use_x_reg ? WT_W'(qx_reg) : WT_ONE;
    assign wy    = use_y_reg ? WT_W'(qy_reg) : WT_ONE;
    assign wprod = wx * wy;
    assign pb    = w_reg * (WT_W+PIX_W)'(sb_reg);
    assign pg    = w_reg * (WT_W+PIX_W)'(sg_reg);
    assign pr    = w_reg * (WT_W+PIX_W)'(sr_reg);

    // Weight is at most 1.0, so the scaled channel term fits in a byte.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_weight)
        begin
            w_reg <= wprod[Q_W+WT_W-1:Q_W];
        end
        if (cmd.mul_chan)
        begin
            pb_reg <= pb[Q_W+PIX_W-1:Q_W];
            pg_reg <= pg[Q_W+PIX_W-1:Q_W];
            pr_reg <= pr[Q_W+PIX_W-1:Q_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ob_reg       <= inside_reg ? sat_add(db_reg, pb_reg) : db_reg;
            og_reg       <= inside_reg ? sat_add(dg_reg, pg_reg) : dg_reg;
            or_reg       <= inside_reg ? sat_add(dr_reg, pr_reg) : dr_reg;
            in_image_reg <= inside_reg;
            ix_reg       <= fx_reg[POS_W-1:0];
            iy_reg       <= fy_reg[POS_W-1:0];
            last_reg     <= last_i_reg;
        end
    end

    assign stat.out_busy = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_b     = ob_reg;
    assign out_g     = og_reg;
    assign out_r     = or_reg;
    assign in_image  = in_image_reg;
    assign image_x   = ix_reg;
    assign image_y   = iy_reg;
    assign last      = last_reg;

endmodule

// ===== sv/feathered_tile_blend_top.sv =====
// Each pixel runs accept, load, check, the 16-step restoring divider for the ramp weights,
// the weight and channel multiplies and the output load, which waits while the previous
// beat is still stalled. A new pixel is accepted only after the last one is through.
// A finished beat waits in the output register while the next pixel is already accepted.
// Reset (rst_n low, asynchronous): registers return to their defaults, scan counters to zero.
// ----------------------------------------------------------------------------
// feathered_tile_blend_top
// Blends a guard-banded tile into a BGR image with feathered linear weights.
// ----------------------------------------------------------------------------
module feathered_tile_blend_top
    import ftb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  src_b,
    input  logic [PIX_W-1:0]  src_g,
    input  logic [PIX_W-1:0]  src_r,
    input  logic [PIX_W-1:0]  dst_b,
    input  logic [PIX_W-1:0]  dst_g,
    input  logic [PIX_W-1:0]  dst_r,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  out_b,
    output logic [PIX_W-1:0]  out_g,
    output logic [PIX_W-1:0]  out_r,
    output logic              in_image,
    output logic [POS_W-1:0]  image_x,
    output logic [POS_W-1:0]  image_y,
    output logic              last
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    ftb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ftb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ftb_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .src_b     (src_b),
        .src_g     (src_g),
        .src_r     (src_r),
        .dst_b     (dst_b),
        .dst_g     (dst_g),
        .dst_r     (dst_r),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_b     (out_b),
        .out_g     (out_g),
        .out_r     (out_r),
        .in_image  (in_image),
        .image_x   (image_x),
        .image_y   (image_y),
        .last      (last)
    );

endmodule

// ===== sv/ftb_assert_mon.sv =====
// ----------------------------------------------------------------------------
// ftb_assert_mon
// Port-level assertions for the tile blender, bound to the top level.
// ----------------------------------------------------------------------------
`include "feathered_tile_blend_top_macros.svh"

module ftb_assert_mon
    import ftb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] out_b,
    input logic [PIX_W-1:0] out_g,
    input logic [PIX_W-1:0] out_r,
    input logic             in_image,
    input logic [POS_W-1:0] image_x,
    input logic [POS_W-1:0] image_y,
    input logic             last
);

    logic [3*PIX_W+2*POS_W+1:0] beat;
    logic                       neg_pos;

    assign beat    = {out_b, out_g, out_r, in_image, image_x, image_y, last};
    assign neg_pos = image_x[POS_W-1] || image_y[POS_W-1];

    `FTB_ASSERT(a_out_hold_valid, out_valid && out_stall |=> out_valid, "stalled beat dropped")
    `FTB_ASSERT(a_out_hold_data, out_valid && out_stall |=> $stable(beat), "stalled beat changed")
    `FTB_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall, "second beat taken early")
    `FTB_ASSERT(a_inside_nonneg, out_valid && in_image |-> !neg_pos, "inside at negative position")

endmodule

bind feathered_tile_blend_top ftb_assert_mon u_assert_mon (.*);
